// File: hw/rtl/u8d_pkg.sv
package u8d_pkg;

  localparam int unsigned CpWidth    = 31;
  localparam int unsigned ByteWidth  = 8;
  localparam int unsigned LeftWidth  = 3;
  localparam int unsigned FifoDepth  = 4;
  localparam int unsigned PtrWidth   = $clog2(FifoDepth);
  localparam int unsigned CountWidth = $clog2(FifoDepth + 1);

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_INVALID = 2'd1;
  localparam logic [1:0] STATUS_TRUNC   = 2'd2;

  typedef struct packed {
    logic [CpWidth-1:0] code_point;
    logic [1:0]         status;
    logic               last;
  } result_t;

  // Results caused by one input item, oldest in r0.
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } step_t;

endpackage

// File: hw/rtl/u8d_ifs.sv
interface u8d_byte_if;
  logic                           valid;
  logic                           ready;
  logic [u8d_pkg::ByteWidth-1:0]  in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface u8d_result_if;
  logic                          valid;
  logic                          ready;
  logic [u8d_pkg::CpWidth-1:0]   code_point;
  logic [1:0]                    status;
  logic                          last;

  modport source (output valid, output code_point, output status, output last, input ready);
  modport sink   (input valid, input code_point, input status, input last, output ready);
endinterface

// File: hw/rtl/u8d_step.sv
module u8d_step (
  input  logic [u8d_pkg::ByteWidth-1:0] in_byte,
  input  logic [u8d_pkg::CpWidth-1:0]   accum,
  input  logic [u8d_pkg::LeftWidth-1:0] bytes_left,
  output logic [u8d_pkg::CpWidth-1:0]   accum_nxt,
  output logic [u8d_pkg::LeftWidth-1:0] bytes_left_nxt,
  output u8d_pkg::step_t                step
);

  logic                           pend;
  logic [u8d_pkg::CpWidth-1:0]    shifted;
  logic [u8d_pkg::LeftWidth-1:0]  left_dec;
  logic [u8d_pkg::CpWidth-1:0]    byte_cp;
  u8d_pkg::result_t               trunc_res;
  u8d_pkg::result_t               new_res;
  logic                           new_emit;

  assign pend     = (bytes_left != '0);
  assign shifted  = {accum[u8d_pkg::CpWidth-7:0], in_byte[5:0]};
  assign left_dec = bytes_left - u8d_pkg::LeftWidth'(1);
  assign byte_cp  = u8d_pkg::CpWidth'(in_byte);

  always_comb begin
    accum_nxt      = '0;
    bytes_left_nxt = '0;
    step           = '0;
    new_emit       = 1'b0;
    new_res        = '0;
    trunc_res      = '{code_point: accum, status: u8d_pkg::STATUS_TRUNC, last: 1'b0};

    if (in_byte[7:6] == 2'b10) begin
      if (pend) begin
        bytes_left_nxt = left_dec;
        if (left_dec == '0) begin
          step.count = 2'd1;
          step.r0    = '{code_point: shifted, status: u8d_pkg::STATUS_OK, last: 1'b1};
        end else begin
          accum_nxt = shifted;
        end
      end else begin
        step.count = 2'd1;
        step.r0    = '{code_point: byte_cp, status: u8d_pkg::STATUS_INVALID, last: 1'b1};
      end
    end else begin
      // Decode the byte as a new character; a pending sequence ends truncated.
      priority if (in_byte[7] == 1'b0) begin
        new_emit = 1'b1;
        new_res  = '{code_point: byte_cp, status: u8d_pkg::STATUS_OK, last: 1'b1};
      end else if (in_byte[7:5] == 3'b110) begin
        accum_nxt      = u8d_pkg::CpWidth'(in_byte[4:0]);
        bytes_left_nxt = u8d_pkg::LeftWidth'(1);
      end else if (in_byte[7:4] == 4'b1110) begin
        accum_nxt      = u8d_pkg::CpWidth'(in_byte[3:0]);
        bytes_left_nxt = u8d_pkg::LeftWidth'(2);
      end else if (in_byte[7:3] == 5'b11110) begin
        accum_nxt      = u8d_pkg::CpWidth'(in_byte[2:0]);
        bytes_left_nxt = u8d_pkg::LeftWidth'(3);
      end else if (in_byte[7:2] == 6'b111110) begin
        accum_nxt      = u8d_pkg::CpWidth'(in_byte[1:0]);
        bytes_left_nxt = u8d_pkg::LeftWidth'(4);
      end else if (in_byte[7:1] == 7'b1111110) begin
        accum_nxt      = u8d_pkg::CpWidth'(in_byte[0]);
        bytes_left_nxt = u8d_pkg::LeftWidth'(5);
      end else begin
        new_emit = 1'b1;
        new_res  = '{code_point: byte_cp, status: u8d_pkg::STATUS_INVALID, last: 1'b1};
      end

      if (pend) begin
        trunc_res.last = ~new_emit;
        step.count     = new_emit ? 2'd2 : 2'd1;
        step.r0        = trunc_res;
        step.r1        = new_res;
      end else begin
        step.count = new_emit ? 2'd1 : 2'd0;
        step.r0    = new_res;
      end
    end
  end

endmodule

// File: hw/rtl/u8d_out_fifo.sv
module u8d_out_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_en,
  input  u8d_pkg::step_t  push,
  output logic            room,
  output logic            head_valid,
  output u8d_pkg::result_t head,
  input  logic            pop
);

  u8d_pkg::result_t                  entry_r [u8d_pkg::FifoDepth];
  logic [u8d_pkg::PtrWidth-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [u8d_pkg::PtrWidth-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [u8d_pkg::CountWidth-1:0]    count_r, count_nxt;
  logic [1:0]                        n_push;
  logic                              do_pop;
  logic [u8d_pkg::PtrWidth-1:0]      wr_ptr_p1;

  // Room for the worst case of two results per item.
  assign room       = (count_r <= u8d_pkg::CountWidth'(u8d_pkg::FifoDepth - 2));
  assign head_valid = (count_r != '0);
  assign head       = entry_r[rd_ptr_r];
  assign do_pop     = pop & head_valid;
  assign n_push     = push_en ? push.count : 2'd0;
  assign wr_ptr_p1  = wr_ptr_r + u8d_pkg::PtrWidth'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + u8d_pkg::PtrWidth'(n_push);
    rd_ptr_nxt = rd_ptr_r + u8d_pkg::PtrWidth'(do_pop);
    count_nxt  = count_r + u8d_pkg::CountWidth'(n_push) - u8d_pkg::CountWidth'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      entry_r[wr_ptr_r] <= push.r0;
    end
    if (n_push == 2'd2) begin
      entry_r[wr_ptr_p1] <= push.r1;
    end
  end

endmodule

// File: hw/rtl/utf8_stream_decoder_core.sv
// Byte-serial UTF-8 decoder, 1 to 6 byte forms.
// in_chan carries one raw byte per item (valid/ready). out_chan carries one
// result per item: code_point, status (0 ok, 1 invalid lead or stray
// continuation byte, 2 truncated sequence) and last, set on the final result
// caused by an input byte. A byte causes zero, one or two results.
// Decode is one pass of logic from the byte and the sequence state into a
// four-entry result queue; a result is written to the queue when its byte is
// accepted. A byte is taken whenever the queue has room for two results, so
// with the receiver taking a result every cycle the block runs at one byte per
// cycle; a byte that ends a pending sequence early and also emits its own
// result pushes two results at once, which the queue absorbs.
// When the receiver stalls the queue fills and in_chan.ready drops once fewer
// than two entries are free; results are held, never dropped.
// Reset empties the queue and clears the sequence state (no sequence pending).
module utf8_stream_decoder_core (
  input  logic              clk,
  input  logic              rst_n,
  u8d_byte_if.sink          in_chan,
  u8d_result_if.source      out_chan
);

  logic [u8d_pkg::CpWidth-1:0]    accum_r, accum_nxt;
  logic [u8d_pkg::LeftWidth-1:0]  bytes_left_r, bytes_left_nxt;
  u8d_pkg::step_t                 step;
  u8d_pkg::result_t               head;
  logic                           room;
  logic                           head_valid;
  logic                           take;

  assign in_chan.ready = room;
  assign take          = in_chan.valid & room;

  u8d_step u_step (
    .in_byte        (in_chan.in_byte),
    .accum          (accum_r),
    .bytes_left     (bytes_left_r),
    .accum_nxt      (accum_nxt),
    .bytes_left_nxt (bytes_left_nxt),
    .step           (step)
  );

  // Advance the sequence state only on an accepted item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r      <= '0;
      bytes_left_r <= '0;
    end else if (take) begin
      accum_r      <= accum_nxt;
      bytes_left_r <= bytes_left_nxt;
    end
  end

  u8d_out_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_en    (take),
    .push       (step),
    .room       (room),
    .head_valid (head_valid),
    .head       (head),
    .pop        (out_chan.ready)
  );

  assign out_chan.valid      = head_valid;
  assign out_chan.code_point = head.code_point;
  assign out_chan.status     = head.status;
  assign out_chan.last       = head.last;

endmodule

// File: tb/sv/utf8_decode_checker.sv
module utf8_decode_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [u8d_pkg::ByteWidth-1:0] in_byte,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [u8d_pkg::CpWidth-1:0]   out_code_point,
  input  logic [1:0]                    out_status,
  input  logic                          out_last,
  output int                            err_count,
  output int                            pending
);

  // Decoder state mirrored from the byte stream.
  logic [u8d_pkg::CpWidth-1:0]   accum;
  logic [u8d_pkg::LeftWidth-1:0] seq_left;
  u8d_pkg::result_t              due_results[$];

  function automatic u8d_pkg::result_t make_result(logic [u8d_pkg::CpWidth-1:0] cp,
                                                   logic [1:0] st);
    u8d_pkg::result_t r;
    r.code_point = cp;
    r.status     = st;
    r.last       = 1'b0;
    return r;
  endfunction

  task automatic decode_byte(input logic [u8d_pkg::ByteWidth-1:0] b);
    u8d_pkg::result_t outs[2];
    int               n;
    n = 0;
    if (b[7:6] == 2'b10) begin
      if (seq_left != '0) begin
        accum    = {accum[u8d_pkg::CpWidth-7:0], b[5:0]};
        seq_left = seq_left - 3'd1;
        if (seq_left == '0) begin
          outs[n] = make_result(accum, u8d_pkg::STATUS_OK);
          n++;
          accum = '0;
        end
      end else begin
        // stray continuation byte
        outs[n] = make_result(u8d_pkg::CpWidth'(b), u8d_pkg::STATUS_INVALID);
        n++;
      end
    end else begin
      // a lead byte ends any pending sequence early
      if (seq_left != '0) begin
        outs[n] = make_result(accum, u8d_pkg::STATUS_TRUNC);
        n++;
        accum    = '0;
        seq_left = '0;
      end
      unique casez (b)
        8'b0???????: begin
          outs[n] = make_result(u8d_pkg::CpWidth'(b[6:0]), u8d_pkg::STATUS_OK);
          n++;
        end
        8'b110?????: begin
          accum    = u8d_pkg::CpWidth'(b[4:0]);
          seq_left = 3'd1;
        end
        8'b1110????: begin
          accum    = u8d_pkg::CpWidth'(b[3:0]);
          seq_left = 3'd2;
        end
        8'b11110???: begin
          accum    = u8d_pkg::CpWidth'(b[2:0]);
          seq_left = 3'd3;
        end
        8'b111110??: begin
          accum    = u8d_pkg::CpWidth'(b[1:0]);
          seq_left = 3'd4;
        end
        8'b1111110?: begin
          accum    = u8d_pkg::CpWidth'(b[0]);
          seq_left = 3'd5;
        end
        default: begin
          outs[n] = make_result(u8d_pkg::CpWidth'(b), u8d_pkg::STATUS_INVALID);
          n++;
        end
      endcase
    end
    if (n > 0) outs[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) due_results.push_back(outs[i]);
  endtask

  always @(posedge clk) begin
    u8d_pkg::result_t got;
    u8d_pkg::result_t want;
    if (!rst_n) begin
      accum     = '0;
      seq_left  = '0;
      due_results.delete();
      err_count <= 0;
    end else begin
      if (out_valid && out_ready) begin
        got.code_point = out_code_point;
        got.status     = out_status;
        got.last       = out_last;
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result cp=%h status=%0d last=%0b",
                   $time, got.code_point, got.status, got.last);
          err_count <= err_count + 1;
        end else begin
          want = due_results.pop_front();
          if (got !== want) begin
            $display({"%0t: mismatch expected cp=%h status=%0d last=%0b,",
                      " got cp=%h status=%0d last=%0b"},
                     $time, want.code_point, want.status, want.last,
                     got.code_point, got.status, got.last);
            err_count <= err_count + 1;
          end
        end
      end
      if (in_valid && in_ready) decode_byte(in_byte);
    end
    pending <= due_results.size();
  end

endmodule

// File: tb/sv/utf8_stream_decoder_core_tb.sv
module utf8_stream_decoder_core_tb;

  localparam int RandomItems = 500;

  logic clk;
  logic rst_n;
  bit   no_idle;
  int   err_count;
  int   pending;
  int   sent;

  u8d_byte_if   in_chan();
  u8d_result_if out_chan();

  utf8_stream_decoder_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  utf8_decode_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_chan.valid),
    .in_ready       (in_chan.ready),
    .in_byte        (in_chan.in_byte),
    .out_valid      (out_chan.valid),
    .out_ready      (out_chan.ready),
    .out_code_point (out_chan.code_point),
    .out_status     (out_chan.status),
    .out_last       (out_chan.last),
    .err_count      (err_count),
    .pending        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("utf8_stream_decoder_core_tb: done, errors");
    $finish;
  end

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] lead_byte(int len);
    logic [7:0] r;
    r = 8'($urandom);
    unique case (len)
      1:       return {1'b0, r[6:0]};
      2:       return {3'b110, r[4:0]};
      3:       return {4'b1110, r[3:0]};
      4:       return {5'b11110, r[2:0]};
      5:       return {6'b111110, r[1:0]};
      default: return {7'b1111110, r[0]};
    endcase
  endfunction

  function automatic logic [7:0] cont_byte();
    logic [7:0] r;
    r = 8'($urandom);
    return {2'b10, r[5:0]};
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int g;
    in_chan.valid   <= 1'b1;
    in_chan.in_byte <= b;
    do @(posedge clk); while (!in_chan.ready);
    sent++;
    g = pick_gap();
    if (g > 0) begin
      in_chan.valid   <= 1'b0;
      in_chan.in_byte <= 8'($urandom);
      repeat (g) @(posedge clk);
    end
  endtask

  // Hold the sender until every expected result has come out.
  task automatic drain();
    in_chan.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic send_list(input logic [7:0] bytes[]);
    foreach (bytes[i]) send_byte(bytes[i]);
  endtask

  // Receiver: bursts of ready with random stalls between them.
  initial begin
    int run;
    int g;
    forever begin
      run = $urandom_range(1, 20);
      out_chan.ready <= 1'b1;
      repeat (run) @(posedge clk);
      g = pick_gap();
      if (g > 0) begin
        out_chan.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  end

  initial begin
    int r;
    int len;
    int ncont;
    no_idle = 1'b0;
    sent    = 0;
    in_chan.valid   <= 1'b0;
    in_chan.in_byte <= '0;
    rst_n <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ascii extremes, full 2/3/6-byte forms, strays, invalid leads, early leads
    send_list('{8'h00, 8'h7f});
    send_list('{8'hc2, 8'ha9});
    send_list('{8'he2, 8'h82, 8'hac});
    send_list('{8'hfd, 8'hbf, 8'hbf, 8'hbf, 8'hbf, 8'hbf});
    send_list('{8'h80, 8'hfe, 8'hff});
    send_list('{8'he2, 8'h41});
    send_list('{8'hc3, 8'hfe});
    send_list('{8'hf8, 8'h80, 8'hc0, 8'hbf});
    drain();

    sent = 0;
    while (sent < RandomItems) begin
      if ($urandom_range(0, 99) < 3) no_idle = ~no_idle;
      if ($urandom_range(0, 99) < 2) drain();
      r = $urandom_range(0, 99);
      len = $urandom_range(1, 6);
      if (r < 70) begin
        send_byte(lead_byte(len));
        for (int i = 1; i < len; i++) send_byte(cont_byte());
      end else if (r < 85) begin
        // cut the sequence short; the next lead ends it
        send_byte(lead_byte(len));
        ncont = (len > 2) ? $urandom_range(0, len - 2) : 0;
        for (int i = 0; i < ncont; i++) send_byte(cont_byte());
      end else begin
        send_byte(8'($urandom));
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("utf8_stream_decoder_core_tb: done, clean");
    end else begin
      $display("utf8_stream_decoder_core_tb: done, errors");
    end
    $finish;
  end

endmodule
